// File: sv/drt_pkg.sv
`timescale 1ns / 1ps
package drt_pkg;

	localparam logic       REQ_PACKET  = 1'b0;
	localparam logic       REQ_REPORT  = 1'b1;
	localparam logic [7:0] VIDEO_MAJOR = 8'd0;

	typedef struct packed {
		logic        req_type;
		logic        new_file;
		logic [63:0] stamp;
		logic [7:0]  major_type;
		logic        payload_ok;
		logic [7:0]  width_hi;
		logic [7:0]  width_lo;
		logic [7:0]  height_hi;
		logic [7:0]  height_lo;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [15:0] best_width;
		logic [15:0] best_height;
		logic [63:0] best_time;
		logic [63:0] no_video_time;
		logic        table_overflow;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELAP,
		ST_ACCT,
		ST_SCAN_P,
		ST_SCAN_R,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept_pkt;
		logic accept_rpt;
		logic calc_elapsed;
		logic acct_idle;
		logic scan_run;
		logic scan_rpt;
		logic insert;
		logic set_ovf;
		logic rpt_out;
	} dp_cmd_t;

	typedef struct packed {
		logic cur_none;
		logic scan_done;
		logic scan_hit;
		logic table_full;
	} dp_sts_t;

endpackage

// File: sv/dominant_resolution_tracker_core.sv
`timescale 1ns / 1ps
// A word is taken when start is high and busy is low; busy stays high until the
// word is fully processed. A packet with no known resolution skips the walk;
// otherwise its length is set by the walk
// over the resolution table, which reads one entry per cycle through a single
// registered read port; a match ends the walk early. A report walks the same table
// and its result word shows on rsp, with done high, for exactly one cycle once
// the walk is over; the receiver
// must capture it then, as it cannot stall the block.
module dominant_resolution_tracker_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  drt_pkg::req_t req,
	output logic          done,
	output drt_pkg::rsp_t rsp
);
	import drt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	drt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	drt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// File: sv/drt_ctrl.sv
`timescale 1ns / 1ps
module drt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             req_type,
	input  drt_pkg::dp_sts_t sts,
	output logic             busy,
	output drt_pkg::dp_cmd_t cmd
);
	import drt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == REQ_REPORT) begin
						cmd.accept_rpt = 1'b1;
						state_d        = ST_SCAN_R;
					end else begin
						cmd.accept_pkt = 1'b1;
						state_d        = ST_ELAP;
					end
				end
			end
			ST_ELAP: begin
				cmd.calc_elapsed = 1'b1;
				state_d          = ST_ACCT;
			end
			ST_ACCT: begin
				if (sts.cur_none) begin
					cmd.acct_idle = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_SCAN_P;
				end
			end
			ST_SCAN_P: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_IDLE;
					if (!sts.scan_hit) begin
						if (sts.table_full) begin
							cmd.set_ovf = 1'b1;
						end else begin
							cmd.insert = 1'b1;
						end
					end
				end
			end
			ST_SCAN_R: begin
				cmd.scan_run = 1'b1;
				cmd.scan_rpt = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.rpt_out = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/drt_dp.sv
`timescale 1ns / 1ps
module drt_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  drt_pkg::req_t    req,
	input  drt_pkg::dp_cmd_t cmd,
	output drt_pkg::dp_sts_t sts,
	output logic             done,
	output drt_pkg::rsp_t    rsp
);
	import drt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] tm;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];

	logic [15:0]   cur_w_q, cur_h_q;
	logic [63:0]   file_off_q, last_adj_q, last_acc_q, idle_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;

	logic [63:0]   adj_q, elapsed_q;
	logic [31:0]   key_q;

	logic [CW-1:0] addr_q;
	logic          hit_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	entry_t        rd_q;

	logic [31:0]   best_key_q;
	logic [63:0]   best_time_q;

	logic          done_q;
	rsp_t          rsp_q;

	logic [63:0]   off;
	logic          accept;
	logic          issue;
	logic          hit_now;
	logic          better;

	assign accept  = cmd.accept_pkt | cmd.accept_rpt;
	assign off     = req.new_file ? last_adj_q : file_off_q;
	assign hit_now = cmd.scan_run && !cmd.scan_rpt && rd_vld_s1 && !hit_q
		&& (rd_q.key == key_q);
	assign issue   = cmd.scan_run && !hit_q && !hit_now && (addr_q < count_q);
	assign better  = cmd.scan_run && cmd.scan_rpt && rd_vld_s1
		&& ((rd_q.tm > best_time_q)
		|| ((rd_q.tm != 64'd0) && (rd_q.tm == best_time_q) && (rd_q.key < best_key_q)));

	assign sts.cur_none   = (key_q[31:16] == 16'd0) || (key_q[15:0] == 16'd0);
	assign sts.scan_done  = !rd_vld_s1 && (hit_q || (addr_q >= count_q));
	assign sts.scan_hit   = hit_q;
	assign sts.table_full = (count_q >= FULL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_w_q     <= '0;
			cur_h_q     <= '0;
			file_off_q  <= '0;
			last_adj_q  <= '0;
			last_acc_q  <= '0;
			idle_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			addr_q      <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			best_key_q  <= '0;
			best_time_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q    <= cmd.rpt_out;
			rd_vld_s1 <= issue;
			if (accept) begin
				addr_q      <= '0;
				hit_q       <= 1'b0;
				best_key_q  <= '0;
				best_time_q <= '0;
			end else begin
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (better) begin
					best_key_q  <= rd_q.key;
					best_time_q <= rd_q.tm;
				end
			end
			if (cmd.accept_pkt) begin
				file_off_q <= off;
				last_adj_q <= req.stamp + off;
				if (req.major_type == VIDEO_MAJOR && req.payload_ok) begin
					cur_w_q <= {req.width_hi, req.width_lo};
					cur_h_q <= {req.height_hi, req.height_lo};
				end
			end
			if (cmd.calc_elapsed) begin
				last_acc_q <= adj_q;
			end
			if (cmd.acct_idle) begin
				idle_q <= idle_q + elapsed_q;
			end
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_pkt) begin
			adj_q <= req.stamp + off;
			key_q <= {cur_w_q, cur_h_q};
		end
		if (cmd.calc_elapsed) begin
			elapsed_q <= adj_q - last_acc_q;
		end
		if (cmd.rpt_out) begin
			rsp_q.found          <= (count_q != '0);
			rsp_q.best_width     <= best_key_q[31:16];
			rsp_q.best_height    <= best_key_q[15:0];
			rsp_q.best_time      <= best_time_q;
			rsp_q.no_video_time  <= idle_q;
			rsp_q.table_overflow <= ovf_q;
		end
	end

	// table: one read port (registered), one write port
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_q <= mem[addr_q[IW-1:0]];
		end
		rd_idx_s1 <= addr_q[IW-1:0];
		if (hit_now) begin
			mem[rd_idx_s1] <= '{key: rd_q.key, tm: rd_q.tm + elapsed_q};
		end else if (cmd.insert) begin
			mem[count_q[IW-1:0]] <= '{key: key_q, tm: elapsed_q};
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: sv/drt_chk.sv
`timescale 1ns / 1ps
module drt_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input drt_pkg::req_t req,
	input logic          done,
	input drt_pkg::rsp_t rsp
);
	import drt_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after accepted word");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_packet_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_PACKET) |=> !done)
		else $error("result right after packet word");

	a_empty_table: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.found |-> (rsp.best_time == 64'd0) && (rsp.best_width == 16'd0)
			&& (rsp.best_height == 16'd0))
		else $error("best entry reported from empty table");

	a_best_known: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.best_time != 64'd0) |-> rsp.found && (rsp.best_width != 16'd0)
			&& (rsp.best_height != 16'd0))
		else $error("best entry has zero dimension");

endmodule

bind dominant_resolution_tracker_core drt_chk u_drt_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

// File: tb/dominant_resolution_tracker_core_test.sv
`timescale 1ns / 1ps
module dominant_resolution_tracker_core_test;
	import drt_pkg::*;

	localparam int TABLE_SIZE = 16;
	localparam int ITEM_COUNT = 1450;

	class resolution_scoreboard;
		bit [15:0] cur_w;
		bit [15:0] cur_h;
		bit [63:0] offset;
		bit [63:0] last_adj;
		bit [63:0] last_acct;
		bit [63:0] idle_total;
		bit [31:0] keys[$];
		bit [63:0] totals[$];
		bit        overflow;
		rsp_t      reports_due[$];
		int        errors;

		function void note_word(req_t w);
			rsp_t      want;
			bit [63:0] adj;
			bit [63:0] elapsed;
			bit [63:0] best;
			bit [31:0] best_key;
			bit [31:0] key;
			bit        hit;
			if (w.req_type == REQ_REPORT) begin
				best = '0;
				best_key = '0;
				foreach (keys[i]) begin
					if (totals[i] > best || (totals[i] != 0 && totals[i] == best &&
						keys[i] < best_key)) begin
						best = totals[i];
						best_key = keys[i];
					end
				end
				want = '0;
				want.found = (keys.size() != 0);
				want.best_width = best_key[31:16];
				want.best_height = best_key[15:0];
				want.best_time = best;
				want.no_video_time = idle_total;
				want.table_overflow = overflow;
				reports_due.push_back(want);
			end else begin
				if (w.new_file)
					offset = last_adj;
				adj = w.stamp + offset;
				last_adj = adj;
				elapsed = adj - last_acct;
				last_acct = adj;
				if (cur_w == 0 || cur_h == 0) begin
					idle_total += elapsed;
				end else begin
					key = {cur_w, cur_h};
					hit = 1'b0;
					foreach (keys[i]) begin
						if (keys[i] == key) begin
							totals[i] += elapsed;
							hit = 1'b1;
						end
					end
					if (!hit) begin
						if (keys.size() < TABLE_SIZE) begin
							keys.push_back(key);
							totals.push_back(elapsed);
						end else begin
							overflow = 1'b1;
						end
					end
				end
				if (w.major_type == VIDEO_MAJOR && w.payload_ok) begin
					cur_w = {w.width_hi, w.width_lo};
					cur_h = {w.height_hi, w.height_lo};
				end
			end
		endfunction

		function void cmp(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %0h", $time, got);
				errors++;
			end else begin
				want = reports_due.pop_front();
				cmp("found", want.found, got.found);
				cmp("best_width", want.best_width, got.best_width);
				cmp("best_height", want.best_height, got.best_height);
				cmp("best_time", want.best_time, got.best_time);
				cmp("no_video_time", want.no_video_time, got.no_video_time);
				cmp("table_overflow", want.table_overflow, got.table_overflow);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	resolution_scoreboard sb = new();
	bit                   quiet;
	logic [63:0]          raw_stamp;

	dominant_resolution_tracker_core #(
		.TABLE_ENTRIES(TABLE_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_word(req);
		end
	end

	function automatic req_t random_word();
		req_t w;
		w.req_type = 1'($urandom);
		w.new_file = 1'($urandom);
		w.stamp = {$urandom, $urandom};
		w.major_type = 8'($urandom);
		w.payload_ok = 1'($urandom);
		w.width_hi = 8'($urandom);
		w.width_lo = 8'($urandom);
		w.height_hi = 8'($urandom);
		w.height_lo = 8'($urandom);
		return w;
	endfunction

	function automatic req_t report_word();
		req_t w;
		w = random_word();
		w.req_type = REQ_REPORT;
		return w;
	endfunction

	function automatic req_t packet_word(bit nf, logic [63:0] st, logic [7:0] mj, bit ok,
		logic [15:0] wd, logic [15:0] ht);
		req_t w;
		w.req_type = REQ_PACKET;
		w.new_file = nf;
		w.stamp = st;
		w.major_type = mj;
		w.payload_ok = ok;
		{w.width_hi, w.width_lo} = wd;
		{w.height_hi, w.height_lo} = ht;
		return w;
	endfunction

	task automatic send_word(input req_t w);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 23)
			gap = $urandom_range(1, 6);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			req <= random_word();
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_reports();
		@(negedge clk);
		start <= 1'b0;
		while (sb.reports_due.size() != 0)
			@(posedge clk);
	endtask

	// packet with a mostly random step on the stamp and a resolution mostly from a small pool
	function automatic req_t random_packet(int pool);
		req_t        w;
		int          r;
		int          k;
		logic [15:0] wd;
		logic [15:0] ht;
		w = random_word();
		w.req_type = REQ_PACKET;
		w.new_file = ($urandom_range(99) < 4);
		r = $urandom_range(99);
		if (w.new_file)
			raw_stamp = r < 50 ? 64'($urandom_range(1000)) : {$urandom, $urandom};
		else if (r < 50)
			raw_stamp += 64'($urandom_range(40) * 8);
		else if (r < 70)
			raw_stamp += 64'($urandom_range(5));
		else if (r < 90)
			raw_stamp += 64'($urandom);
		else if (r < 97)
			raw_stamp += {$urandom, $urandom} >> 1;
		else
			raw_stamp = {$urandom, $urandom};
		w.stamp = raw_stamp;
		r = $urandom_range(99);
		if (r < 70)
			w.major_type = VIDEO_MAJOR;
		w.payload_ok = ($urandom_range(99) < 85);
		k = $urandom_range(pool - 1);
		wd = 16'(160 * (k % 6 + 1));
		ht = 16'(120 * (k / 6 + 1));
		r = $urandom_range(99);
		if (r < 3)
			wd = '0;
		else if (r < 6)
			ht = '0;
		else if (r < 10 && pool > 10) begin
			wd = 16'($urandom);
			ht = 16'($urandom);
		end
		{w.width_hi, w.width_lo} = wd;
		{w.height_hi, w.height_lo} = ht;
		return w;
	endfunction

	initial begin
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		quiet = 1'b0;
		raw_stamp = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(report_word());
		send_word(packet_word(1'b0, 64'd0, 8'd255, 1'b1, 16'hFFFF, 16'hFFFF));
		send_word(packet_word(1'b0, 64'd100, VIDEO_MAJOR, 1'b0, 16'd640, 16'd480));
		send_word(packet_word(1'b0, 64'd150, VIDEO_MAJOR, 1'b1, 16'd0, 16'd480));
		send_word(packet_word(1'b0, 64'd200, VIDEO_MAJOR, 1'b1, 16'd640, 16'd0));
		send_word(packet_word(1'b0, 64'd300, VIDEO_MAJOR, 1'b1, 16'd640, 16'd480));
		// zero elapsed time still opens an entry
		send_word(packet_word(1'b0, 64'd300, VIDEO_MAJOR, 1'b1, 16'd320, 16'd240));
		send_word(report_word());
		send_word(packet_word(1'b0, 64'd400, 8'd7, 1'b1, 16'd1, 16'd1));
		send_word(packet_word(1'b0, 64'd400, VIDEO_MAJOR, 1'b1, 16'd640, 16'd480));
		send_word(packet_word(1'b0, 64'd500, VIDEO_MAJOR, 1'b1, 16'hFFFF, 16'hFFFF));
		// tie: smaller resolution wins
		send_word(report_word());
		send_word(packet_word(1'b1, 64'd0, VIDEO_MAJOR, 1'b0, 16'd0, 16'd0));
		send_word(packet_word(1'b0, '1, VIDEO_MAJOR, 1'b1, 16'h00FF, 16'hFF00));
		send_word(report_word());
		send_word(packet_word(1'b1, 64'd2, 8'd128, 1'b1, 16'd0, 16'd0));
		send_word(packet_word(1'b0, 64'd3, VIDEO_MAJOR, 1'b1, 16'd1, 16'd1));
		send_word(packet_word(1'b0, 64'd10, VIDEO_MAJOR, 1'b1, 16'hFFFF, 16'hFFFF));
		// wraps the largest entry back to zero
		send_word(packet_word(1'b0, 64'd11, 8'd1, 1'b1, 16'd2, 16'd2));
		send_word(report_word());
		drain_reports();

		raw_stamp = 64'd11;
		for (int n = 0; n < ITEM_COUNT; n++) begin
			quiet = (n >= 500 && n < 750);
			if (n % 300 == 150)
				drain_reports();
			if ($urandom_range(99) < 8)
				send_word(report_word());
			else
				send_word(random_packet(n < 900 ? 10 : 24));
		end
		send_word(report_word());

		drain_reports();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.reports_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
